// File: hdl/rphc_pkg.sv
package rphc_pkg;

  localparam int unsigned TempW    = 12;
  localparam int unsigned SecW     = 16;
  localparam int unsigned StepW    = 3;
  localparam int unsigned StepSlots = 4;
  localparam int unsigned MaxSteps = 4;

  localparam logic [TempW-1:0] IdleTarget = 12'd80;
  localparam logic [TempW:0]   WinAbove   = 13'd12;
  localparam logic [TempW:0]   WinBelow   = 13'd40;

  localparam logic [2:0]  ResetStepCount     = 3'd2;
  localparam logic [47:0] ResetStepTargets   = 48'd3768920;
  localparam logic [63:0] ResetStepDurations = 64'd655540;
  localparam logic [7:0]  ResetLookaheadSecs = 8'd30;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_MANUAL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_STEP_COUNT     = 2'd0,
    REG_STEP_TARGETS   = 2'd1,
    REG_STEP_DURATIONS = 2'd2,
    REG_LOOKAHEAD_SECS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cmd_e             command;
    logic [TempW-1:0] measured_temperature;
    logic [TempW-1:0] manual_target;
    logic             manual_enable;
  } in_item_t;

  typedef struct packed {
    logic             heater_on;
    logic             profile_active;
    logic [StepW-1:0] step_index;
    logic [SecW-1:0]  step_seconds;
    logic [SecW-1:0]  seconds_to_go;
    logic [TempW-1:0] current_target;
    logic             profile_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  step_count;
    logic [47:0] step_targets;
    logic [63:0] step_durations;
    logic [7:0]  lookahead_secs;
  } cfg_t;

  function automatic logic [TempW-1:0] target_of(logic [47:0] targets, logic [StepW-1:0] idx);
    logic [TempW-1:0] val;
    val = '0;
    if (idx < StepW'(StepSlots)) begin
      val = targets[TempW*idx[1:0] +: TempW];
    end
    return val;
  endfunction

  function automatic logic [SecW-1:0] duration_of(logic [63:0] durs, logic [StepW-1:0] idx);
    logic [SecW-1:0] val;
    val = '0;
    if (idx < StepW'(StepSlots)) begin
      val = durs[SecW*idx[1:0] +: SecW];
    end
    return val;
  endfunction

  function automatic logic [StepW:0] steps_in_use(logic [2:0] count);
    logic [StepW:0] n;
    n = {1'b0, count};
    if (n == '0) begin
      n = (StepW+1)'(1);
    end
    if (n > (StepW+1)'(MaxSteps)) begin
      n = (StepW+1)'(MaxSteps);
    end
    return n;
  endfunction

endpackage

// File: hdl/rphc_stage.sv
module rphc_stage #(
  parameter type data_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  data_t data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output data_t data_o
);

  logic  valid_q, valid_d;
  data_t data_q;
  logic  load;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;
  assign valid_d = load ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/rphc_cfg_regs.sv
module rphc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output rphc_pkg::cfg_t   cfg_o
);

  import rphc_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count     <= ResetStepCount;
      cfg_q.step_targets   <= ResetStepTargets;
      cfg_q.step_durations <= ResetStepDurations;
      cfg_q.lookahead_secs <= ResetLookaheadSecs;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STEP_COUNT:     cfg_q.step_count     <= cfg_data_i[2:0];
        REG_STEP_TARGETS:   cfg_q.step_targets   <= cfg_data_i[47:0];
        REG_STEP_DURATIONS: cfg_q.step_durations <= cfg_data_i;
        REG_LOOKAHEAD_SECS: cfg_q.lookahead_secs <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/rphc_core.sv
module rphc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rphc_pkg::in_item_t  item_i,
  input  rphc_pkg::cfg_t      cfg_i,
  output rphc_pkg::out_item_t result_o
);

  import rphc_pkg::*;

  logic             enabled_q, enabled_d;
  logic [TempW-1:0] target_q, target_d;
  logic [TempW-1:0] prev_q, prev_d;
  logic             heater_q, heater_d;
  logic             running_q, running_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SecW-1:0]  secs_q, secs_d;
  logic             done;

  logic [TempW-1:0]   meas;
  logic signed [TempW:0]   slope;
  logic signed [21:0] ahead;
  logic               heat_now;
  logic [TempW-1:0]   tgt_eff;
  logic               in_window;
  logic [SecW-1:0]    secs_cnt;
  logic [StepW-1:0]   step_adv;
  logic [SecW-1:0]    secs_adv;

  // heater lookahead: measured + dead time * slope, all signed
  assign meas  = item_i.measured_temperature;
  assign slope = $signed({1'b0, meas}) - $signed({1'b0, prev_q});
  assign ahead = $signed({10'b0, meas}) + $signed({1'b0, cfg_i.lookahead_secs}) * slope;
  assign heat_now = enabled_q && (meas < target_q) && (ahead < $signed({10'b0, target_q}));

  // profile stepping on a tick
  assign tgt_eff   = (secs_q == '0) ? target_of(cfg_i.step_targets, step_q) : target_q;
  assign in_window = ({1'b0, tgt_eff} < {1'b0, meas} + WinAbove)
                  && ({1'b0, tgt_eff} + WinBelow > {1'b0, meas});
  assign secs_cnt  = in_window ? secs_q + SecW'(1) : secs_q;

  always_comb begin
    step_adv = step_q;
    secs_adv = secs_cnt;
    if (secs_cnt >= duration_of(cfg_i.step_durations, step_q)) begin
      step_adv = step_q + StepW'(1);
      secs_adv = '0;
    end
  end

  always_comb begin
    enabled_d = enabled_q;
    target_d  = target_q;
    prev_d    = prev_q;
    heater_d  = heater_q;
    running_d = running_q;
    step_d    = step_q;
    secs_d    = secs_q;
    done      = 1'b0;
    unique case (item_i.command)
      CMD_TICK: begin
        heater_d = heat_now;
        prev_d   = meas;
        if (running_q) begin
          target_d = tgt_eff;
          step_d   = step_adv;
          secs_d   = secs_adv;
          if ({1'b0, step_adv} >= steps_in_use(cfg_i.step_count)) begin
            running_d = 1'b0;
            enabled_d = 1'b0;
            target_d  = IdleTarget;
            done      = 1'b1;
          end
        end
      end
      CMD_START: begin
        step_d    = '0;
        secs_d    = '0;
        running_d = 1'b1;
        enabled_d = 1'b1;
      end
      CMD_STOP: begin
        running_d = 1'b0;
        enabled_d = 1'b0;
        target_d  = IdleTarget;
      end
      CMD_MANUAL: begin
        target_d  = item_i.manual_target;
        enabled_d = item_i.manual_enable;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      target_q  <= IdleTarget;
      prev_q    <= '0;
      heater_q  <= 1'b0;
      running_q <= 1'b0;
      step_q    <= '0;
      secs_q    <= '0;
    end else if (fire_i) begin
      enabled_q <= enabled_d;
      target_q  <= target_d;
      prev_q    <= prev_d;
      heater_q  <= heater_d;
      running_q <= running_d;
      step_q    <= step_d;
      secs_q    <= secs_d;
    end
  end

  always_comb begin
    result_o.heater_on       = heater_d;
    result_o.profile_active  = running_d;
    result_o.step_index      = step_d;
    result_o.step_seconds    = secs_d;
    result_o.seconds_to_go   = running_d ?
                               duration_of(cfg_i.step_durations, step_d) - secs_d : '0;
    result_o.current_target  = target_d;
    result_o.profile_done    = done;
  end

endmodule

// File: hdl/reflow_profile_heater_control.sv
// Reflow oven heater controller with a stepped temperature profile, in quarter degrees.
// Each input transaction is a one-second tick, a start, a stop or a manual target write,
// and gives exactly one result transaction. A transaction is registered on input, worked
// through the heater lookahead (one 8x13 multiply) and profile stepping, and registered
// on output, so one transaction is taken every cycle while the output is not stalled.
// Configuration writes are always ready and are meant to be issued only while no
// transaction is in flight.
module reflow_profile_heater_control (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rphc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rphc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  import rphc_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      res_stall;
  out_item_t result;
  cfg_t      cfg;
  logic      fire;

  assign fire = item_valid && !res_stall;

  rphc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rphc_stage #(.data_t(in_item_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_item_i),
    .valid_o (item_valid),
    .stall_i (res_stall),
    .data_o  (item)
  );

  rphc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  rphc_stage #(.data_t(out_item_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .stall_o (res_stall),
    .data_i  (result),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_item_o)
  );

endmodule

// File: hdl/rphc_checker.sv
module rphc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rphc_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rphc_pkg::out_item_t out_item_o
);

  import rphc_pkg::*;

  // a finished profile is no longer running
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.profile_done |-> !out_item_o.profile_active)
    else $error("profile done while still running");

  // a finished profile falls back to the idle target
  a_done_idle_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.profile_done |-> out_item_o.current_target == IdleTarget)
    else $error("profile done without idle target");

  // no countdown while idle
  a_idle_no_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.profile_active |-> out_item_o.seconds_to_go == '0)
    else $error("seconds to go nonzero while idle");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result transaction changed");

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input transaction changed");

endmodule

bind reflow_profile_heater_control rphc_checker u_rphc_checker (.*);

// File: test/tb_reflow_profile_heater_control.sv
module tb_reflow_profile_heater_control;
  import rphc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  reflow_profile_heater_control uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // controller state mirror
  cfg_t             cfg_copy;
  logic             enable_q;
  logic [TempW-1:0] target_q;
  logic [TempW-1:0] last_temp_q;
  logic             relay_q;
  logic             running_q;
  logic [StepW-1:0] step_q;
  logic [SecW-1:0]  step_secs_q;

  out_item_t pending_status_q[$];

  int  fail_count    = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  profiles_done = 0;
  int  settings_done = 0;
  bit  sender_quiet  = 1'b0;
  bit  receiver_quiet = 1'b0;
  int  hold_request  = 0;

  function automatic logic [TempW-1:0] step_target_at(logic [StepW-1:0] idx);
    if (idx >= StepSlots) return '0;
    return cfg_copy.step_targets[int'(idx)*TempW +: TempW];
  endfunction

  function automatic logic [SecW-1:0] step_duration_at(logic [StepW-1:0] idx);
    if (idx >= StepSlots) return '0;
    return cfg_copy.step_durations[int'(idx)*SecW +: SecW];
  endfunction

  function automatic out_item_t predict_heater_status(in_item_t it);
    out_item_t r;
    int        t;
    int        ahead;
    int        tgt;
    int        steps;
    logic      done;
    done = 1'b0;
    case (it.command)
      CMD_TICK: begin
        t = int'(it.measured_temperature);
        tgt = int'(target_q);
        ahead = t + int'(cfg_copy.lookahead_secs) * (t - int'(last_temp_q));
        relay_q = enable_q && (t < tgt) && (ahead < tgt);
        last_temp_q = it.measured_temperature;
        if (running_q) begin
          if (step_secs_q == '0) target_q = step_target_at(step_q);
          tgt = int'(target_q);
          if (tgt < t + int'(WinAbove) && tgt > t - int'(WinBelow)) begin
            step_secs_q = step_secs_q + 16'd1;
          end
          if (step_secs_q >= step_duration_at(step_q)) begin
            step_q = step_q + 3'd1;
            step_secs_q = '0;
          end
          steps = (cfg_copy.step_count == '0) ? 1 : int'(cfg_copy.step_count);
          if (steps > int'(MaxSteps)) steps = int'(MaxSteps);
          if (int'(step_q) >= steps) begin
            running_q = 1'b0;
            enable_q = 1'b0;
            target_q = IdleTarget;
            done = 1'b1;
            profiles_done++;
          end
        end
      end
      CMD_START: begin
        step_q = '0;
        step_secs_q = '0;
        running_q = 1'b1;
        enable_q = 1'b1;
      end
      CMD_STOP: begin
        running_q = 1'b0;
        enable_q = 1'b0;
        target_q = IdleTarget;
      end
      CMD_MANUAL: begin
        target_q = it.manual_target;
        enable_q = it.manual_enable;
      end
    endcase
    r.heater_on       = relay_q;
    r.profile_active  = running_q;
    r.step_index      = step_q;
    r.step_seconds    = step_secs_q;
    r.seconds_to_go   = running_q ? step_duration_at(step_q) - step_secs_q : '0;
    r.current_target  = target_q;
    r.profile_done    = done;
    return r;
  endfunction

  function automatic in_item_t make_item(cmd_e c, int meas, int tgt, bit en);
    in_item_t it;
    it.command              = c;
    it.measured_temperature = TempW'(meas);
    it.manual_target        = TempW'(tgt);
    it.manual_enable        = en;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return make_item(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_status_q.push_back(predict_heater_status(it));
    items_sent++;
  endtask

  task automatic finish_pending();
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_config(cfg_t c);
    finish_pending();
    write_reg(REG_STEP_COUNT, 64'(c.step_count));
    write_reg(REG_STEP_TARGETS, 64'(c.step_targets));
    write_reg(REG_STEP_DURATIONS, c.step_durations);
    write_reg(REG_LOOKAHEAD_SECS, 64'(c.lookahead_secs));
    cfg_valid_i <= 1'b0;
    cfg_copy = c;
    settings_done++;
  endtask

  // start, then mostly ticks that track the active step target
  task automatic run_profile_sequence();
    int len;
    int base;
    int meas;
    int pick;
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    len = $urandom_range(3, 50);
    for (int k = 0; k < len && running_q; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        base = (step_secs_q == '0) ? int'(step_target_at(step_q)) : int'(target_q);
        meas = base + int'($urandom_range(0, 50)) - 39;
        if (meas < 0) meas = 0;
        if (meas > 4095) meas = 4095;
        send_item(make_item(CMD_TICK, meas, $urandom_range(0, 4095), 1'b0));
      end else if (pick < 90) begin
        send_item(make_item(CMD_TICK, $urandom_range(0, 4095), 0, 1'b1));
      end else if (pick < 95) begin
        send_item(make_item(CMD_MANUAL, 0, $urandom_range(0, 4095),
                            1'($urandom_range(0, 1))));
      end else if (pick < 97) begin
        send_item(make_item(CMD_STOP, 0, 0, 1'b0));
      end else begin
        send_item(make_item(CMD_START, 0, 0, 1'b0));
      end
    end
  endtask

  task automatic test_idle_heater();
    send_item(make_item(CMD_TICK, 0, 0, 1'b0));
    send_item(make_item(CMD_MANUAL, 0, 4095, 1'b1));
    send_item(make_item(CMD_TICK, 4095, 0, 1'b0));
    send_item(make_item(CMD_TICK, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 100, 0, 1'b0));
  endtask

  task automatic test_profile_steps();
    cfg_t c;
    c.step_count     = 3'd3;
    c.step_targets   = 48'h000_190_12C_0C8;
    c.step_durations = 64'h0000_0000_0002_0001;
    c.lookahead_secs = 8'd0;
    write_config(c);
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 200, 0, 1'b0));
    send_item(make_item(CMD_TICK, 300, 0, 1'b0));
    send_item(make_item(CMD_TICK, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 300, 0, 1'b0));
    send_item(make_item(CMD_TICK, 4095, 0, 1'b0));
  endtask

  task automatic test_command_effects();
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 200, 0, 1'b0));
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    send_item(make_item(CMD_MANUAL, 0, 1000, 1'b0));
    send_item(make_item(CMD_TICK, 990, 0, 1'b0));
    send_item(make_item(CMD_STOP, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 50, 0, 1'b0));
  endtask

  task automatic test_step_count_limits();
    cfg_t c;
    c = cfg_copy;
    c.step_count = 3'd0;
    write_config(c);
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 200, 0, 1'b0));
    c.step_count     = 3'd7;
    c.lookahead_secs = 8'd255;
    write_config(c);
    send_item(make_item(CMD_START, 0, 0, 1'b0));
    send_item(make_item(CMD_TICK, 200, 0, 1'b0));
    // count lowered below the running step
    c.step_count = 3'd1;
    write_config(c);
    send_item(make_item(CMD_TICK, 300, 0, 1'b0));
  endtask

  task automatic test_backpressure();
    sender_quiet = 1'b1;
    hold_request = 150;
    repeat (3) run_profile_sequence();
    repeat (10) send_item(noise_item());
    sender_quiet = 1'b0;
    finish_pending();
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int   phase_end;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        c = '0;
      end else if (phase == 1) begin
        c = '1;
      end else begin
        c.step_count = 3'($urandom_range(0, 7));
        for (int i = 0; i < int'(StepSlots); i++) begin
          c.step_targets[i*TempW +: TempW] = TempW'($urandom_range(0, 4095));
          c.step_durations[i*SecW +: SecW] = ($urandom_range(0, 9) == 0) ?
                                             SecW'($urandom) : SecW'($urandom_range(0, 6));
        end
        c.lookahead_secs = 8'($urandom_range(0, 255));
      end
      write_config(c);
      sender_quiet   = (phase == 2);
      receiver_quiet = (phase == 2 || phase == 5);
      phase_end = items_sent + 60;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) run_profile_sequence();
        else send_item(noise_item());
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // output stall pacing, one draw per result transaction
  initial begin : result_pacing
    int n;
    forever begin
      n = receiver_quiet ? 0 : $urandom_range(0, 13);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (pending_status_q.size() == 0) begin
        $error("result transaction with no expected status");
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        if (out_item_o.heater_on !== want.heater_on) begin
          $error("heater_on expected %0d actual %0d", want.heater_on, out_item_o.heater_on);
          fail_count++;
        end
        if (out_item_o.profile_active !== want.profile_active) begin
          $error("profile_active expected %0d actual %0d",
                 want.profile_active, out_item_o.profile_active);
          fail_count++;
        end
        if (out_item_o.step_index !== want.step_index) begin
          $error("step_index expected %0d actual %0d", want.step_index, out_item_o.step_index);
          fail_count++;
        end
        if (out_item_o.step_seconds !== want.step_seconds) begin
          $error("step_seconds expected %0d actual %0d",
                 want.step_seconds, out_item_o.step_seconds);
          fail_count++;
        end
        if (out_item_o.seconds_to_go !== want.seconds_to_go) begin
          $error("seconds_to_go expected %0d actual %0d",
                 want.seconds_to_go, out_item_o.seconds_to_go);
          fail_count++;
        end
        if (out_item_o.current_target !== want.current_target) begin
          $error("current_target expected %0d actual %0d",
                 want.current_target, out_item_o.current_target);
          fail_count++;
        end
        if (out_item_o.profile_done !== want.profile_done) begin
          $error("profile_done expected %0d actual %0d",
                 want.profile_done, out_item_o.profile_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4800000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cfg_copy.step_count     = ResetStepCount;
    cfg_copy.step_targets   = ResetStepTargets;
    cfg_copy.step_durations = ResetStepDurations;
    cfg_copy.lookahead_secs = ResetLookaheadSecs;
    enable_q    = 1'b0;
    target_q    = IdleTarget;
    last_temp_q = '0;
    relay_q     = 1'b0;
    running_q   = 1'b0;
    step_q      = '0;
    step_secs_q = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_heater();
    test_profile_steps();
    test_command_effects();
    test_step_count_limits();
    test_backpressure();
    test_random_traffic();
    finish_pending();
    repeat (8) @(posedge clk_i);
    $display("covered %0d input transactions and %0d results over %0d register settings",
             items_sent, results_seen, settings_done);
    $display("%0d profiles ran to completion, %0d mismatches", profiles_done, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: reflow_profile_heater_control.f
hdl/rphc_pkg.sv
hdl/rphc_stage.sv
hdl/rphc_cfg_regs.sv
hdl/rphc_core.sv
hdl/reflow_profile_heater_control.sv
hdl/rphc_checker.sv
test/tb_reflow_profile_heater_control.sv
